[rtl/core/token_stream_lexer_core_assert.svh]
// Assertion macros for the lexer core. Each expects clk and rst_n in scope.
`ifndef TOKEN_STREAM_LEXER_CORE_ASSERT_SVH
`define TOKEN_STREAM_LEXER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define TSLC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed: next-cycle implication");

// Condition must never be seen out of reset.
`define TSLC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lexer assertion failed: forbidden condition");

`endif

[rtl/core/tslc_pkg.sv]
`default_nettype none

package tslc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [5:0] NAME_COUNT_CAP = 6'd33;
  localparam logic [5:0] NAME_LIMIT_MAX = 6'd32;
  localparam logic [5:0] NAME_LIMIT_RESET = 6'd32;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_SPACE,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SLASH,
    CLS_STAR,
    CLS_PUNCT,
    CLS_OTHER
  } tslc_class_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NAME,
    MODE_INT,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_STAR
  } tslc_mode_t;

  typedef enum logic [2:0] {
    KIND_END,
    KIND_NAME,
    KIND_INT,
    KIND_PUNCT,
    KIND_UNKNOWN,
    KIND_TOO_LONG
  } tslc_kind_t;

  // One classified source byte as it sits in the queue.
  typedef struct packed {
    logic [7:0]  ch;
    tslc_class_t cls;
  } tslc_item_t;

  typedef struct packed {
    tslc_kind_t  kind;
    logic [63:0] int_value;
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [5:0]  name_length;
    logic [7:0]  punct_char;
    logic        last;
  } tslc_tok_t;

  localparam tslc_tok_t TOK_ZERO = '{kind: KIND_END, default: '0};

  function automatic tslc_class_t classify(input logic [7:0] c);
    tslc_class_t cls;
    if (c == 8'h00) begin
      cls = CLS_END;
    end else if (c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0c || c == 8'h0b) begin
      cls = CLS_SPACE;
    end else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f) begin
      cls = CLS_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = CLS_DIGIT;
    end else if (c == CHAR_SLASH) begin
      cls = CLS_SLASH;
    end else if (c == 8'h2a) begin
      cls = CLS_STAR;
    end else if (c == 8'h28 || c == 8'h29 || c == 8'h3a || c == 8'h3b || c == 8'h3d ||
                 c == 8'h7b || c == 8'h7d || c == 8'h2c || c == 8'h40 || c == 8'h3f) begin
      cls = CLS_PUNCT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tslc_front.sv]
`default_nettype none
`include "token_stream_lexer_core_assert.svh"

module tslc_front
  import tslc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  output logic            q_valid,
  output tslc_item_t      q_item,
  input  wire logic       q_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  tslc_item_t              queue_r [QUEUE_DEPTH];
  logic       [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic       [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic       [QCNT_W-1:0] count_r, count_nxt;
  logic                    push;

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Classify on the way in so the scanner gets the class code with each byte.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{ch: in_char_in, cls: classify(in_char_in)};
    end
  end

  `TSLC_ASSERT_NEVER(a_queue_overfill, count_r > QCNT_W'(QUEUE_DEPTH))
  `TSLC_ASSERT_IMP(a_pop_nonempty, q_pop, count_r != '0)

endmodule

`default_nettype wire

[rtl/core/tslc_back.sv]
`default_nettype none
`include "token_stream_lexer_core_assert.svh"

module tslc_back
  import tslc_pkg::*;
#(
  parameter int NAME_BYTES = 16,
  parameter int INT_WIDTH  = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire tslc_item_t q_item,
  output logic            q_pop,
  input  wire logic [5:0] name_limit,
  output logic            out_valid,
  input  wire logic       out_stall,
  output tslc_tok_t       out_tok
);

  localparam int STORE_BITS = NAME_BYTES * 8;

  tslc_mode_t              mode_r, mode_nxt;
  logic [STORE_BITS-1:0]   store_r, store_nxt;
  logic [5:0]              count_r, count_nxt;
  logic [INT_WIDTH-1:0]    accum_r, accum_nxt;
  logic                    out_valid_r;
  tslc_tok_t               out_tok_r;
  logic                    pend_valid_r;
  tslc_tok_t               pend_tok_r;

  logic                    slot_free;
  logic                    emit_a, emit_b, idle_step;
  tslc_tok_t               tok_a, tok_b, tok_first;
  logic [127:0]            name_full;
  logic [63:0]             int_full;

  assign slot_free = !out_valid_r || !out_stall;
  // A queued second token blocks the scanner until it moves to the output.
  assign q_pop     = q_valid && !pend_valid_r && slot_free;
  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;

  always_comb begin
    mode_nxt  = mode_r;
    store_nxt = store_r;
    count_nxt = count_r;
    accum_nxt = accum_r;
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    idle_step = 1'b0;
    tok_a     = TOK_ZERO;
    tok_b     = TOK_ZERO;
    name_full = '0;
    name_full[STORE_BITS-1:0] = store_r;
    int_full  = '0;
    int_full[INT_WIDTH-1:0] = accum_r;

    case (mode_r)
      MODE_NAME: begin
        if (q_item.cls == CLS_LETTER) begin
          for (int i = 0; i < NAME_BYTES; i++) begin
            if (count_r == 6'(i)) begin
              store_nxt[i*8 +: 8] = q_item.ch;
            end
          end
          if (count_r < NAME_COUNT_CAP) begin
            count_nxt = count_r + 6'd1;
          end
        end else begin
          emit_a          = 1'b1;
          tok_a.name_low  = name_full[63:0];
          tok_a.name_high = name_full[127:64];
          if (count_r > name_limit) begin
            tok_a.kind        = KIND_TOO_LONG;
            tok_a.name_length = name_limit;
          end else begin
            tok_a.kind        = KIND_NAME;
            tok_a.name_length = count_r;
          end
          idle_step = 1'b1;
        end
      end
      MODE_INT: begin
        if (q_item.cls == CLS_DIGIT) begin
          // times ten as two shifted adds, wrapping at the accumulator width
          accum_nxt = (accum_r << 3) + (accum_r << 1) + INT_WIDTH'(q_item.ch[3:0]);
        end else begin
          emit_a          = 1'b1;
          tok_a.kind      = KIND_INT;
          tok_a.int_value = int_full;
          idle_step       = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (q_item.cls == CLS_STAR) begin
          mode_nxt = MODE_COMMENT;
        end else begin
          emit_a           = 1'b1;
          tok_a.kind       = KIND_UNKNOWN;
          tok_a.punct_char = CHAR_SLASH;
          idle_step        = 1'b1;
        end
      end
      MODE_COMMENT, MODE_STAR: begin
        if (q_item.cls == CLS_END) begin
          emit_a     = 1'b1;
          tok_a.kind = KIND_END;
          mode_nxt   = MODE_IDLE;
          store_nxt  = '0;
          count_nxt  = '0;
          accum_nxt  = '0;
        end else if (q_item.cls == CLS_STAR) begin
          mode_nxt = MODE_STAR;
        end else if (q_item.cls == CLS_SLASH && mode_r == MODE_STAR) begin
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_COMMENT;
        end
      end
      default: begin
        idle_step = 1'b1;
      end
    endcase

    // Handle the byte as a fresh start once any pending token is closed.
    if (idle_step) begin
      mode_nxt  = MODE_IDLE;
      store_nxt = '0;
      count_nxt = '0;
      accum_nxt = '0;
      case (q_item.cls)
        CLS_END: begin
          emit_b     = 1'b1;
          tok_b.kind = KIND_END;
        end
        CLS_SPACE: begin
        end
        CLS_LETTER: begin
          mode_nxt       = MODE_NAME;
          store_nxt[7:0] = q_item.ch;
          count_nxt      = 6'd1;
        end
        CLS_DIGIT: begin
          mode_nxt  = MODE_INT;
          accum_nxt = INT_WIDTH'(q_item.ch[3:0]);
        end
        CLS_SLASH: begin
          mode_nxt = MODE_SLASH;
        end
        CLS_PUNCT: begin
          emit_b           = 1'b1;
          tok_b.kind       = KIND_PUNCT;
          tok_b.punct_char = q_item.ch;
        end
        default: begin
          emit_b           = 1'b1;
          tok_b.kind       = KIND_UNKNOWN;
          tok_b.punct_char = q_item.ch;
        end
      endcase
    end

    tok_a.last = !emit_b;
    tok_b.last = 1'b1;
    tok_first  = emit_a ? tok_a : tok_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      store_r <= '0;
      count_r <= '0;
      accum_r <= '0;
    end else if (q_pop) begin
      mode_r  <= mode_nxt;
      store_r <= store_nxt;
      count_r <= count_nxt;
      accum_r <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (pend_valid_r && slot_free) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= 1'b0;
    end else if (q_pop && (emit_a || emit_b)) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= emit_a && emit_b;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid_r && slot_free) begin
      out_tok_r <= pend_tok_r;
    end else if (q_pop && (emit_a || emit_b)) begin
      out_tok_r  <= tok_first;
      pend_tok_r <= tok_b;
    end
  end

  `TSLC_ASSERT_IMP(a_pend_behind_out, pend_valid_r, out_valid_r)
  `TSLC_ASSERT_NXT(a_pair_split, q_pop && emit_a && emit_b,
                   out_valid_r && pend_valid_r && !out_tok_r.last)
  `TSLC_ASSERT_NEVER(a_count_cap, count_r > NAME_COUNT_CAP)
  `TSLC_ASSERT_IMP(a_name_nonempty, mode_r == MODE_NAME, count_r != '0)

endmodule

`default_nettype wire

[rtl/core/token_stream_lexer_core.sv]
// Byte-serial tokenizer. Source bytes enter on the in_ channel (zero ends the
// input) and tokens leave on the out_ channel, one token per request, with
// out_last_of_run set on the final token a byte caused. A small classifying
// queue sits in front of the scanner, and a single output register plus one
// spare token slot sit behind it, so both channels can stall independently.
// The block takes one byte per cycle while in_stall is low; a byte that both
// closes a pending name, integer or slash and forms a token of its own yields
// two tokens and holds the scanner while the second token waits for the
// output register. A byte's first token passes through the queue and then the
// output register. cfg_max_name_length is the longest name accepted before a
// name-too-long token; values above 32 act as 32. Write it only while the
// block is idle.
`default_nettype none

module token_stream_lexer_core
  import tslc_pkg::*;
#(
  parameter int NAME_BYTES = 16,
  parameter int INT_WIDTH  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_token_kind,
  output logic [63:0]      out_int_value,
  output logic [63:0]      out_name_low,
  output logic [63:0]      out_name_high,
  output logic [5:0]       out_name_length,
  output logic [7:0]       out_punct_char,
  output logic             out_last_of_run,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_max_name_length
);

  logic [5:0] max_len_r;
  logic [5:0] name_limit;
  logic       q_valid;
  logic       q_pop;
  tslc_item_t q_item;
  tslc_tok_t  tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= NAME_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_max_name_length;
    end
  end

  assign name_limit = (max_len_r > NAME_LIMIT_MAX) ? NAME_LIMIT_MAX : max_len_r;

  tslc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  tslc_back #(
    .NAME_BYTES (NAME_BYTES),
    .INT_WIDTH  (INT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .name_limit (name_limit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tok    (tok)
  );

  assign out_token_kind  = tok.kind;
  assign out_int_value   = tok.int_value;
  assign out_name_low    = tok.name_low;
  assign out_name_high   = tok.name_high;
  assign out_name_length = tok.name_length;
  assign out_punct_char  = tok.punct_char;
  assign out_last_of_run = tok.last;

endmodule

`default_nettype wire
